>>> rtl/srsw_pkg.sv
`timescale 1ns / 1ps

package srsw_pkg;

	localparam int SEQ_COUNT     = 32;
	localparam int SEQ_W         = $clog2(SEQ_COUNT);
	localparam int HALF_WIN      = SEQ_COUNT / 2;
	localparam int WINDOW_RESET  = 10;
	localparam int TIMEOUT_RESET = 20;
	localparam int TIMER_MAX     = 255;
	localparam int ADDR_W        = 4;

	localparam logic [1:0] KIND_SEND = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_SEND   = 2'd1;
	localparam logic [1:0] ACT_RESEND = 2'd2;
	localparam logic [1:0] ACT_ACK    = 2'd3;

	localparam logic [1:0] REG_WINDOW  = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_TOTAL   = 2'd2;

	typedef logic [SEQ_W-1:0] seq_t;

	typedef struct packed {
		logic [4:0]  window_size;
		logic [7:0]  timeout_ticks;
		logic [15:0] total_packets;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  seq_out;
		logic [15:0] block_index;
		logic [4:0]  window_base;
		logic        done_res;
	} res_t;

	typedef struct packed {
		logic       acked;
		logic [7:0] timer;
	} entry_t;

	localparam int     ENTRY_W     = $bits(entry_t);
	localparam entry_t ENTRY_RESET = '{acked: 1'b1, timer: 8'd0};

	function automatic seq_t seq_inc(seq_t x);
		return (x == SEQ_W'(SEQ_COUNT - 1)) ? '0 : x + 1'b1;
	endfunction

	// Distance from one sequence number forward to another, modulo the space.
	function automatic seq_t seq_dist(seq_t from, seq_t to);
		logic [SEQ_W:0] s;
		s = (SEQ_W + 1)'(SEQ_COUNT) + {1'b0, to} - {1'b0, from};
		if (s >= (SEQ_W + 1)'(SEQ_COUNT))
			s = s - (SEQ_W + 1)'(SEQ_COUNT);
		return s[SEQ_W-1:0];
	endfunction

	// Data block carried by the packet with sequence number s.
	function automatic logic [15:0] block_of(seq_t s, logic [15:0] sent, seq_t nxt);
		return sent - 16'(seq_dist(s, nxt));
	endfunction

endpackage

>>> rtl/srsw_ram.sv
`timescale 1ns / 1ps

module srsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/srsw_cfg.sv
`timescale 1ns / 1ps

module srsw_cfg
	import srsw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [4:0]  window_q;
	logic [7:0]  timeout_q;
	logic [15:0] total_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= 5'(WINDOW_RESET);
			timeout_q <= 8'(TIMEOUT_RESET);
			total_q   <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_WINDOW:  window_q  <= pwdata[4:0];
				REG_TIMEOUT: timeout_q <= pwdata[7:0];
				REG_TOTAL:   total_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW:  prdata = {27'd0, window_q};
			REG_TIMEOUT: prdata = {24'd0, timeout_q};
			REG_TOTAL:   prdata = {16'd0, total_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg = '{window_size: window_q, timeout_ticks: timeout_q, total_packets: total_q};

endmodule

>>> rtl/srsw_ctrl.sv
`timescale 1ns / 1ps

module srsw_ctrl
	import srsw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_kind,
	input  logic [5:0]         in_code,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res,
	output logic               ram_we,
	output seq_t               ram_waddr,
	output entry_t             ram_wdata,
	output seq_t               ram_raddr,
	input  logic [ENTRY_W-1:0] ram_rdata
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SEND_CHK = 3'd1;
	localparam logic [2:0] ST_SLIDE    = 3'd2;
	localparam logic [2:0] ST_TICK     = 3'd3;
	localparam logic [2:0] ST_DONE     = 3'd4;

	logic [2:0]           state_q, state_d;
	seq_t                 base_q, base_d;
	seq_t                 next_q, next_d;
	logic [15:0]          sent_q, sent_d;
	logic [1:0]           act_q, act_d;
	seq_t                 seq_q, seq_d;
	logic [15:0]          blk_q, blk_d;
	seq_t                 rd_ptr_q, rd_ptr_d;
	seq_t                 rd_cnt_q, rd_cnt_d;
	logic                 found_q, found_d;
	logic                 chk_vld_s1, chk_vld_d;
	seq_t                 chk_addr_s1, chk_addr_d;
	logic                 rd_vld_s1;
	logic [SEQ_COUNT-1:0] vld_q;

	logic                 rd_en;
	entry_t               rd_entry;
	seq_t                 outst;
	seq_t                 eff_w;
	seq_t                 base_inc;
	logic [5:0]           code_m1;
	logic                 code_ok;
	seq_t                 ack_idx;
	logic [7:0]           tick_timer;

	// Entries never written read as acked with a cleared timer.
	assign rd_entry = rd_vld_s1 ? entry_t'(ram_rdata) : ENTRY_RESET;
	assign outst    = seq_dist(base_q, next_q);
	assign base_inc = seq_inc(base_q);
	assign code_m1  = in_code - 6'd1;
	assign code_ok  = (in_code != 6'd0) && (code_m1 < SEQ_COUNT);
	assign ack_idx  = code_m1[SEQ_W-1:0];

	always_comb begin
		if (cfg.window_size == 5'd0)
			eff_w = SEQ_W'(1);
		else if (cfg.window_size > HALF_WIN)
			eff_w = SEQ_W'(HALF_WIN);
		else
			eff_w = SEQ_W'(cfg.window_size);
	end

	assign tick_timer = (!rd_entry.acked && rd_entry.timer != 8'(TIMER_MAX)) ?
		rd_entry.timer + 8'd1 : rd_entry.timer;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		state_d    = state_q;
		base_d     = base_q;
		next_d     = next_q;
		sent_d     = sent_q;
		act_d      = act_q;
		seq_d      = seq_q;
		blk_d      = blk_q;
		rd_ptr_d   = rd_ptr_q;
		rd_cnt_d   = rd_cnt_q;
		found_d    = found_q;
		chk_vld_d  = 1'b0;
		chk_addr_d = chk_addr_s1;
		ram_we     = 1'b0;
		ram_waddr  = chk_addr_s1;
		ram_wdata  = ENTRY_RESET;
		ram_raddr  = rd_ptr_q;
		rd_en      = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					act_d   = ACT_NONE;
					seq_d   = '0;
					blk_d   = '0;
					state_d = ST_DONE;
					case (in_kind)
						KIND_SEND: begin
							if (sent_q < cfg.total_packets && outst < eff_w) begin
								ram_raddr = next_q;
								rd_en     = 1'b1;
								state_d   = ST_SEND_CHK;
							end
						end
						KIND_ACK: begin
							if (code_ok && seq_dist(base_q, ack_idx) < outst) begin
								ram_we    = 1'b1;
								ram_waddr = ack_idx;
								ram_wdata = ENTRY_RESET;
								act_d     = ACT_ACK;
								seq_d     = ack_idx;
								blk_d     = block_of(ack_idx, sent_q, next_q);
								if (ack_idx == base_q) begin
									base_d = base_inc;
									if (base_inc != next_q) begin
										ram_raddr = base_inc;
										rd_en     = 1'b1;
										state_d   = ST_SLIDE;
									end
								end
							end
						end
						KIND_TICK: begin
							rd_ptr_d = base_q;
							rd_cnt_d = '0;
							found_d  = 1'b0;
							state_d  = ST_TICK;
						end
						default: ;
					endcase
				end
			end
			ST_SEND_CHK: begin
				if (rd_entry.acked) begin
					ram_we    = 1'b1;
					ram_waddr = next_q;
					ram_wdata = '{acked: 1'b0, timer: 8'd0};
					act_d     = ACT_SEND;
					seq_d     = next_q;
					blk_d     = sent_q;
					next_d    = seq_inc(next_q);
					sent_d    = sent_q + 16'd1;
				end
				state_d = ST_DONE;
			end
			ST_SLIDE: begin
				// One entry per cycle: the read of the following slot overlaps the check.
				if (rd_entry.acked) begin
					base_d = base_inc;
					if (base_inc != next_q) begin
						ram_raddr = base_inc;
						rd_en     = 1'b1;
					end else begin
						state_d = ST_DONE;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_TICK: begin
				// Write back the slot read last cycle while the next slot is read.
				if (chk_vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = chk_addr_s1;
					if (!found_q && !rd_entry.acked && tick_timer > cfg.timeout_ticks) begin
						ram_wdata = '{acked: rd_entry.acked, timer: 8'd0};
						found_d   = 1'b1;
						act_d     = ACT_RESEND;
						seq_d     = chk_addr_s1;
						blk_d     = block_of(chk_addr_s1, sent_q, next_q);
					end else begin
						ram_wdata = '{acked: rd_entry.acked, timer: tick_timer};
					end
				end
				if (rd_cnt_q != outst) begin
					ram_raddr  = rd_ptr_q;
					rd_en      = 1'b1;
					chk_vld_d  = 1'b1;
					chk_addr_d = rd_ptr_q;
					rd_ptr_d   = seq_inc(rd_ptr_q);
					rd_cnt_d   = rd_cnt_q + 1'b1;
				end else if (!chk_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			base_q     <= '0;
			next_q     <= '0;
			sent_q     <= '0;
			rd_cnt_q   <= '0;
			found_q    <= 1'b0;
			chk_vld_s1 <= 1'b0;
			vld_q      <= '0;
		end else begin
			state_q    <= state_d;
			base_q     <= base_d;
			next_q     <= next_d;
			sent_q     <= sent_d;
			rd_cnt_q   <= rd_cnt_d;
			found_q    <= found_d;
			chk_vld_s1 <= chk_vld_d;
			if (ram_we)
				vld_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		act_q       <= act_d;
		seq_q       <= seq_d;
		blk_q       <= blk_d;
		rd_ptr_q    <= rd_ptr_d;
		chk_addr_s1 <= chk_addr_d;
		rd_vld_s1   <= vld_q[ram_raddr];
	end

	assign res = '{
		action:      act_q,
		seq_out:     5'(seq_q),
		block_index: blk_q,
		window_base: 5'(base_q),
		done_res:    (sent_q >= cfg.total_packets) && (base_q == next_q)
	};

	a_outst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outst <= HALF_WIN)
		else $error("outstanding range exceeds half the sequence space");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && rd_en) |-> (ram_waddr != ram_raddr))
		else $error("read and write of the same slot in one cycle");

	a_sent_only_on_send: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SEND_CHK) |=> $stable(sent_q))
		else $error("sent count changed outside a send");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(act_q) && $stable(blk_q)))
		else $error("pending result changed before it was taken");

endmodule

>>> rtl/selective_repeat_sender_window.sv
`timescale 1ns / 1ps

// Selective-repeat ARQ sender window. Each input transfer is an event: a send
// request, a received ack (ack byte in s_tdata) or a timer tick, chosen by
// s_tuser. Every event produces exactly one output transfer with the action
// taken, the sequence number and data block involved, the window base after
// the event and a completion flag. Per-slot acked flags and wait timers live
// in one single-port-read RAM, so the cost of an event is set by how many
// slots it must visit through that RAM. A send request checks the slot it
// would use, an ack checks each slot after the acked base slot while the base
// slides, and a tick reads and writes back every outstanding slot in turn.
// The default window is 10 and the largest effective window is 16. Results
// sit in an output register; a new event is taken once the previous result
// has moved there. Registers (APB): window_size at 0x0, timeout_ticks at
// 0x4, total_packets at 0x8; write them only while no event is in flight.
module selective_repeat_sender_window
	import srsw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [5:0] ack_code, [7:6] zero
	input  logic [1:0]        s_tuser,  // [1:0] kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,  // [1:0] action, [6:2] seq_out,
	                                    // [22:7] block_index, [27:23] window_base,
	                                    // [28] done_res, [31:29] zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t               cfg;
	res_t               res;
	logic               res_valid;
	logic               res_ready;
	logic               ram_we;
	seq_t               ram_waddr;
	entry_t             ram_wdata;
	seq_t               ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               m_tvalid_q;
	logic [31:0]        m_tdata_q;

	srsw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srsw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SEQ_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_code   (s_tdata[5:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_ready)
			m_tvalid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			m_tdata_q <= {3'd0, res.done_res, res.window_base, res.block_index,
				res.seq_out, res.action};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

import srsw_pkg::*;

// Tracks the sender window: slot flags, wait timers, base and next sequence
// numbers. Each accepted event yields the one result the block must return.
class window_tracker;
	bit          acked[SEQ_COUNT];
	int unsigned wait_ticks[SEQ_COUNT];
	int unsigned base_q;
	int unsigned next_q;
	int unsigned issued;
	int unsigned win_cfg;
	int unsigned limit_cfg;
	int unsigned total_cfg;
	res_t        due_results[$];
	int unsigned errors;

	function new();
		foreach (acked[i]) begin
			acked[i] = 1'b1;
			wait_ticks[i] = 0;
		end
		base_q = 0;
		next_q = 0;
		issued = 0;
		win_cfg = WINDOW_RESET;
		limit_cfg = TIMEOUT_RESET;
		total_cfg = 0;
		errors = 0;
	endfunction

	function int unsigned ahead(int unsigned from, int unsigned to);
		return (to + SEQ_COUNT - from) % SEQ_COUNT;
	endfunction

	function int unsigned pending();
		return due_results.size();
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			REG_WINDOW:  win_cfg = value & 32'h1f;
			REG_TIMEOUT: limit_cfg = value & 32'hff;
			REG_TOTAL:   total_cfg = value & 32'hffff;
			default: ;
		endcase
	endfunction

	// Mostly acks for outstanding slots, with the base favored so that the
	// window slides; the rest fall just past the window or anywhere.
	function logic [5:0] pick_ack_code();
		int unsigned outst;
		int unsigned r;
		outst = ahead(base_q, next_q);
		r = $urandom_range(0, 99);
		if (outst != 0 && r < 30)
			return 6'(base_q + 1);
		if (outst != 0 && r < 80)
			return 6'((base_q + $urandom_range(0, outst - 1)) % SEQ_COUNT + 1);
		if (r < 90)
			return 6'(next_q + 1);
		return 6'($urandom_range(0, 63));
	endfunction

	function void take_event(logic [1:0] kind, logic [5:0] code);
		res_t        r;
		int unsigned outst;
		int unsigned win;
		int unsigned idx;
		int unsigned j;
		int          i;
		bit          hit;
		r = '0;
		outst = ahead(base_q, next_q);
		case (kind)
			KIND_SEND: begin
				win = (win_cfg < 1) ? 1 : ((win_cfg > HALF_WIN) ? HALF_WIN : win_cfg);
				if (issued < total_cfg && outst < win && acked[next_q]) begin
					r.action = ACT_SEND;
					r.seq_out = 5'(next_q);
					r.block_index = 16'(issued);
					acked[next_q] = 1'b0;
					wait_ticks[next_q] = 0;
					next_q = (next_q + 1) % SEQ_COUNT;
					issued = (issued + 1) & 32'hffff;
				end
			end
			KIND_ACK: begin
				idx = int'(code) - 1;
				if (code != 0 && idx < SEQ_COUNT && ahead(base_q, idx) < outst) begin
					r.action = ACT_ACK;
					r.seq_out = 5'(idx);
					r.block_index = 16'(issued - ahead(idx, next_q));
					acked[idx] = 1'b1;
					wait_ticks[idx] = 0;
					if (idx == base_q) begin
						while (base_q != next_q && acked[base_q])
							base_q = (base_q + 1) % SEQ_COUNT;
					end
				end
			end
			KIND_TICK: begin
				for (i = 0; i < outst; i++) begin
					j = (base_q + i) % SEQ_COUNT;
					if (!acked[j] && wait_ticks[j] < TIMER_MAX)
						wait_ticks[j]++;
				end
				hit = 1'b0;
				for (i = 0; i < outst && !hit; i++) begin
					j = (base_q + i) % SEQ_COUNT;
					if (!acked[j] && wait_ticks[j] > limit_cfg) begin
						hit = 1'b1;
						r.action = ACT_RESEND;
						r.seq_out = 5'(j);
						r.block_index = 16'(issued - ahead(j, next_q));
						wait_ticks[j] = 0;
					end
				end
			end
			default: ;
		endcase
		r.window_base = 5'(base_q);
		r.done_res = (issued >= total_cfg && base_q == next_q);
		due_results.push_back(r);
	endfunction

	function void match_result(logic [31:0] d);
		res_t got;
		res_t want;
		got.action = d[1:0];
		got.seq_out = d[6:2];
		got.block_index = d[22:7];
		got.window_base = d[27:23];
		got.done_res = d[28];
		if (due_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("Unexpected result: action %0d seq %0d block %0d base %0d done %0d",
					got.action, got.seq_out, got.block_index, got.window_base, got.done_res);
			return;
		end
		want = due_results.pop_front();
		if (got.action !== want.action || got.seq_out !== want.seq_out ||
		    got.block_index !== want.block_index || got.window_base !== want.window_base ||
		    got.done_res !== want.done_res) begin
			errors++;
			if (errors <= 10) begin
				$display("Mismatch: expected action %0d seq %0d block %0d base %0d done %0d",
					want.action, want.seq_out, want.block_index, want.window_base,
					want.done_res);
				$display("          got      action %0d seq %0d block %0d base %0d done %0d",
					got.action, got.seq_out, got.block_index, got.window_base,
					got.done_res);
			end
		end
	endfunction
endclass

module testbench;

	localparam logic [1:0] KIND_IDLE = 2'd3;  // unused event kind, must be ignored
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 24;
	localparam int RANDOM_EVENTS  = 500;
	localparam int RX_HOLD_CYCLES = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;   // [5:0] ack_code, [7:6] zero
	logic [1:0]        s_tuser = '0;   // [1:0] kind
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;        // [1:0] action, [6:2] seq_out, [22:7] block_index,
	                                   // [27:23] window_base, [28] done_res
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	window_tracker tracker = new();
	bit            tx_steady = 1'b0;
	bit            rx_hold_req = 1'b0;
	int unsigned   cycle_count = 0;

	selective_repeat_sender_window dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: alternates between steady and choppy stretches, and takes
	// one long hold when the stimulus asks for it.
	initial begin : result_sink
		int unsigned stall;
		int unsigned mode_left;
		bit          choppy;
		stall = 0;
		mode_left = 0;
		choppy = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				tracker.match_result(m_tdata);
			if (mode_left == 0) begin
				choppy = ($urandom_range(0, 2) != 0);
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = RX_HOLD_CYCLES;
			end else if (stall == 0 && choppy && $urandom_range(0, 3) == 0) begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) :
					$urandom_range(1, 3);
			end
			if (stall != 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one event and returns at the edge where its transfer completes.
	// Valid stays high into the next event when no gap follows.
	task automatic push_event(logic [1:0] kind, logic [5:0] code);
		int unsigned gap;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 55)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {2'b00, code};
		do @(posedge clk); while (!s_tready);
		tracker.take_event(kind, code);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		tracker.set_reg(idx, value);
	endtask

	// Stops offering and waits until every pending result has been returned.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned done_events;
		int unsigned phase;
		int unsigned n;
		int unsigned r;
		int unsigned i;
		logic [31:0] win;
		logic [31:0] lim;
		logic [31:0] tot;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no blocks to send, so nothing can go out.
		push_event(KIND_SEND, 6'd0);
		push_event(KIND_TICK, 6'd63);
		push_event(KIND_ACK, 6'd0);
		push_event(KIND_ACK, 6'd1);
		push_event(KIND_ACK, 6'd63);
		push_event(KIND_IDLE, 6'd42);
		settle();

		// A window of zero acts as one; a timeout of one resends on the second tick.
		write_reg(REG_WINDOW, 32'd0);
		write_reg(REG_TIMEOUT, 32'd1);
		write_reg(REG_TOTAL, 32'd2);
		push_event(KIND_SEND, 6'd0);
		push_event(KIND_SEND, 6'd0);
		push_event(KIND_TICK, 6'd0);
		push_event(KIND_TICK, 6'd0);
		push_event(KIND_ACK, 6'd2);
		push_event(KIND_ACK, 6'd1);
		push_event(KIND_ACK, 6'd1);
		push_event(KIND_SEND, 6'd0);
		push_event(KIND_ACK, 6'd2);
		push_event(KIND_SEND, 6'd0);
		settle();

		// Oversized window, zero timeout, largest transfer; duplicate ack and slide.
		write_reg(REG_WINDOW, 32'd31);
		write_reg(REG_TIMEOUT, 32'd0);
		write_reg(REG_TOTAL, 32'd65535);
		push_event(KIND_SEND, 6'd0);
		push_event(KIND_SEND, 6'd0);
		push_event(KIND_SEND, 6'd0);
		push_event(KIND_ACK, 6'd4);
		push_event(KIND_ACK, 6'd4);
		push_event(KIND_TICK, 6'd0);
		push_event(KIND_ACK, 6'd3);
		push_event(KIND_ACK, 6'd32);
		push_event(KIND_ACK, 6'd5);
		settle();

		// Timers must stop at their ceiling: after many ticks with the largest
		// timeout, a lower timeout must fire at once.
		write_reg(REG_WINDOW, 32'd4);
		write_reg(REG_TIMEOUT, 32'd255);
		write_reg(REG_TOTAL, tracker.issued + 4);
		repeat (4) push_event(KIND_SEND, 6'($urandom));
		repeat (260) push_event(KIND_TICK, 6'($urandom));
		settle();
		write_reg(REG_TIMEOUT, 32'd100);
		push_event(KIND_TICK, 6'd0);

		done_events = 0;
		phase = 0;
		while (done_events < RANDOM_EVENTS) begin
			settle();
			r = $urandom_range(0, 5);
			case (r)
				0: win = 32'd0;
				1: win = 32'd1;
				2: win = HALF_WIN;
				3: win = 32'd31;
				4: win = $urandom_range(17, 30);
				default: win = $urandom_range(2, 15);
			endcase
			r = $urandom_range(0, 9);
			case (r)
				0: lim = 32'd0;
				1: lim = 32'd255;
				2: lim = $urandom_range(0, 255);
				default: lim = $urandom_range(1, 6);
			endcase
			r = $urandom_range(0, 9);
			case (r)
				0: tot = 32'd0;
				1: tot = 32'd65535;
				default: tot = (tracker.issued + $urandom_range(0, 40)) & 32'hffff;
			endcase
			write_reg(REG_WINDOW, win);
			write_reg(REG_TIMEOUT, lim);
			write_reg(REG_TOTAL, tot);
			tx_steady = ($urandom_range(0, 3) == 0);
			if (phase == 2)
				rx_hold_req = 1'b1;
			n = $urandom_range(30, 90);
			for (i = 0; i < n; i++) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					push_event(KIND_SEND, 6'($urandom));
				else if (r < 72)
					push_event(KIND_ACK, tracker.pick_ack_code());
				else if (r < 95)
					push_event(KIND_TICK, 6'($urandom));
				else
					push_event(KIND_IDLE, 6'($urandom));
			end
			done_events += n;
			phase++;
		end
		settle();

		if (tracker.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
